>>> src/assert_macros.svh
// Assertion helpers, used by wave_grid_stencil_step_unit.sv.
// With SYNTH defined, the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked on every rising edge, skipped while reset is high.
`define GSP_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge.
`define GSP_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GSP_ASSERT_RST(lbl, clk, rst, prop, msg)
`define GSP_ASSERT(lbl, clk, prop, msg)

`endif

`endif

>>> src/gsp_pkg.sv
package gsp_pkg;

  // Default grid bounds.
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Field widths.
  localparam int HW     = 24;  // height, Q12.12
  localparam int SW     = 25;  // slope
  localparam int KW     = 18;  // coefficient, Q2.16
  localparam int TW     = 32;  // time values
  localparam int GW     = 7;   // grid size registers
  localparam int IXW    = 6;   // row and column inputs
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  // Operation codes.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_DISTURB = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Register indexes.
  localparam logic [CFG_IW-1:0] REG_GRID_ROWS  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_GRID_COLS  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_TIME_STEP  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_COEF_PREV  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_COEF_CTR   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_COEF_NB    = 3'd5;

  // Register reset values.
  localparam logic [GW-1:0]        RST_GRID_ROWS = 7'd64;
  localparam logic [GW-1:0]        RST_GRID_COLS = 7'd64;
  localparam logic [TW-1:0]        RST_TIME_STEP = 32'd30000;
  localparam logic signed [KW-1:0] RST_COEF_PREV = -18'sd65536;
  localparam logic signed [KW-1:0] RST_COEF_CTR  = 18'sd65536;
  localparam logic signed [KW-1:0] RST_COEF_NB   = 18'sd16384;

  localparam logic signed [31:0] H_MAX = 32'sd8388607;
  localparam logic signed [31:0] H_MIN = -32'sd8388608;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TICK,
    ST_SW0,
    ST_SW1,
    ST_SW2,
    ST_SWM,
    ST_SWS,
    ST_SWW,
    ST_DRD,
    ST_DWR,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_FIN
  } state_t;

  // Clamp a signed value to the height range.
  function automatic logic signed [HW-1:0] sat24(input logic signed [31:0] v);
    logic signed [HW-1:0] r;
    if (v > H_MAX) begin
      r = H_MAX[HW-1:0];
    end else if (v < H_MIN) begin
      r = H_MIN[HW-1:0];
    end else begin
      r = v[HW-1:0];
    end
    return r;
  endfunction

endpackage

>>> src/gsp_grid_mem.sv
module gsp_grid_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic signed [gsp_pkg::HW-1:0]  wdata,
  input  logic [AW-1:0]                  raddr0,
  input  logic [AW-1:0]                  raddr1,
  output logic signed [gsp_pkg::HW-1:0]  rdata0,
  output logic signed [gsp_pkg::HW-1:0]  rdata1
);
  import gsp_pkg::*;

  logic signed [HW-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

>>> src/gsp_update.sv
module gsp_update (
  input  logic                           clk,
  input  logic signed [gsp_pkg::KW-1:0]  coef_prev,
  input  logic signed [gsp_pkg::KW-1:0]  coef_center,
  input  logic signed [gsp_pkg::KW-1:0]  coef_neighbour,
  input  logic signed [gsp_pkg::HW-1:0]  prev_h,
  input  logic signed [gsp_pkg::HW-1:0]  cur_h,
  input  logic signed [gsp_pkg::HW+1:0]  nsum,
  output logic signed [gsp_pkg::HW-1:0]  res
);
  import gsp_pkg::*;

  localparam int PW  = KW + HW;      // product of coefficient and height
  localparam int NPW = KW + HW + 2;  // product of coefficient and neighbour sum
  localparam int AW  = NPW + 2;      // sum of three products

  logic signed [PW-1:0]  p_prev;
  logic signed [PW-1:0]  p_cur;
  logic signed [NPW-1:0] p_nb;
  logic signed [AW-1:0]  acc;
  logic signed [AW-1:0]  rnd;
  logic signed [AW-17:0] q;

  // First stage: the three products.
  always_ff @(posedge clk) begin
    p_prev <= coef_prev * prev_h;
    p_cur  <= coef_center * cur_h;
    p_nb   <= coef_neighbour * nsum;
  end

  // Second stage: exact sum.
  always_ff @(posedge clk) begin
    acc <= AW'(p_prev) + AW'(p_cur) + AW'(p_nb);
  end

  // Round half up to Q12.12 and saturate.
  always_comb begin
    rnd = acc + AW'(32768);
    q   = rnd[AW-1:16];
    res = sat24(32'(q));
  end

endmodule

>>> src/wave_grid_stencil_step_unit.sv
// Two-buffer 2-D wave equation solver on a grid of up to MAX_ROWS x MAX_COLS
// Q12.12 heights, held in two single-write, dual-read grid memories.
// An item is taken when start is high and busy is low; op selects a tick
// (elapsed_time), a disturb (row, col, magnitude) or a read (row, col).
// Each item gives one result, shown for one cycle with done high; the
// receiver cannot hold it off. Registers are written through cfg_we,
// cfg_idx and cfg_wdata, one per cycle; the user must write them only while
// no item is in flight, as the block itself does not enforce this.
// A stepping tick sweeps every interior cell (read four neighbours on the
// current grid's two ports, then center and previous value, a multiply
// stage and a sum stage, write back). After reset both grids are cleared,
// one address per cycle over all MAX_ROWS*MAX_COLS addresses (4096 at the
// default size), with busy held high; configuration writes are taken during
// that pass.
`include "assert_macros.svh"

module wave_grid_stencil_step_unit #(
  parameter int MAX_ROWS = gsp_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gsp_pkg::DEF_MAX_COLS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        op,
  input  logic [gsp_pkg::TW-1:0]            elapsed_time,
  input  logic [gsp_pkg::IXW-1:0]           row,
  input  logic [gsp_pkg::IXW-1:0]           col,
  input  logic signed [gsp_pkg::HW-1:0]     magnitude,
  input  logic                              cfg_we,
  input  logic [gsp_pkg::CFG_IW-1:0]        cfg_idx,
  input  logic [gsp_pkg::CFG_DW-1:0]        cfg_wdata,
  output logic                              done,
  output logic signed [gsp_pkg::HW-1:0]     height,
  output logic signed [gsp_pkg::SW-1:0]     slope_x,
  output logic signed [gsp_pkg::SW-1:0]     slope_z,
  output logic                              stepped,
  output logic                              rejected
);
  import gsp_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RN    = $clog2(MAX_ROWS + 1);
  localparam int CN    = $clog2(MAX_COLS + 1);
  localparam int RCN   = (RN > CN) ? RN : CN;
  localparam int IW    = ((RCN > GW) ? RCN : GW) + 1;
  localparam logic [AW-1:0] COL_OFS = AW'(MAX_COLS);

  // Configuration registers.
  logic [GW-1:0]        grid_rows;
  logic [GW-1:0]        grid_cols;
  logic [TW-1:0]        time_step;
  logic signed [KW-1:0] coef_prev;
  logic signed [KW-1:0] coef_center;
  logic signed [KW-1:0] coef_neighbour;

  // Control and working registers.
  state_t               state;
  state_t               state_next;
  logic                 current_is_b;
  logic [TW-1:0]        time_acc;
  logic [AW-1:0]        clr_addr;
  logic [IW-1:0]        row_q;
  logic [IW-1:0]        col_q;
  logic signed [HW-1:0] mag_q;
  logic [TW-1:0]        elapsed_q;
  logic [2:0]           k_q;
  logic [IW-1:0]        sw_i;
  logic [IW-1:0]        sw_j;
  logic signed [HW-1:0] up_q;
  logic signed [HW-1:0] dn_q;
  logic signed [HW-1:0] ht_q;
  logic signed [HW-1:0] rt_q;
  logic signed [HW-1:0] lf_q;
  logic signed [HW+1:0] nsum_q;

  // Combinational helpers.
  logic [IW-1:0]        eff_rows;
  logic [IW-1:0]        eff_cols;
  logic [IW-1:0]        in_row;
  logic [IW-1:0]        in_col;
  logic                 dist_ok;
  logic                 read_ok;
  logic [TW:0]          acc_sum;
  logic [TW-1:0]        acc_sat;
  logic                 step_now;
  logic                 sweep_last;
  logic [AW-1:0]        sw_addr;
  logic [AW-1:0]        op_addr;
  logic [AW-1:0]        d_addr;
  logic signed [HW-1:0] d_delta;
  logic signed [HW:0]   d_sum;
  logic signed [HW+1:0] nsum_next;
  logic signed [HW-1:0] rd_dn;

  // Memory requests.
  logic                 clr;
  logic                 cwe;
  logic                 pwe;
  logic [AW-1:0]        cra0;
  logic [AW-1:0]        cra1;
  logic [AW-1:0]        pra;
  logic signed [HW-1:0] cw_data;
  logic signed [HW-1:0] pw_data;

  logic                 a_we;
  logic                 b_we;
  logic [AW-1:0]        a_waddr;
  logic [AW-1:0]        b_waddr;
  logic signed [HW-1:0] a_wdata;
  logic signed [HW-1:0] b_wdata;
  logic [AW-1:0]        a_raddr0;
  logic [AW-1:0]        b_raddr0;
  logic signed [HW-1:0] a_rd0;
  logic signed [HW-1:0] a_rd1;
  logic signed [HW-1:0] b_rd0;
  logic signed [HW-1:0] b_rd1;
  logic signed [HW-1:0] cur_rd0;
  logic signed [HW-1:0] cur_rd1;
  logic signed [HW-1:0] prv_rd0;

  assign busy = (state != ST_IDLE);

  // Grid size in use, clamped to the supported range.
  always_comb begin
    eff_rows = IW'(grid_rows);
    if (eff_rows < IW'(3)) begin
      eff_rows = IW'(3);
    end else if (eff_rows > IW'(MAX_ROWS)) begin
      eff_rows = IW'(MAX_ROWS);
    end
    eff_cols = IW'(grid_cols);
    if (eff_cols < IW'(3)) begin
      eff_cols = IW'(3);
    end else if (eff_cols > IW'(MAX_COLS)) begin
      eff_cols = IW'(MAX_COLS);
    end
  end

  // Index checks on the incoming item.
  always_comb begin
    in_row  = IW'(row);
    in_col  = IW'(col);
    dist_ok = (in_row > IW'(1)) && (in_row + IW'(2) < eff_rows) &&
              (in_col > IW'(1)) && (in_col + IW'(2) < eff_cols);
    read_ok = (in_row < eff_rows) && (in_col < eff_cols);
  end

  // Time accumulation saturates at the top of the range.
  always_comb begin
    acc_sum  = {1'b0, time_acc} + {1'b0, elapsed_q};
    acc_sat  = acc_sum[TW] ? '1 : acc_sum[TW-1:0];
    step_now = (acc_sat >= time_step);
  end

  // Addresses and disturb arithmetic.
  always_comb begin
    sw_addr    = AW'(32'(sw_i) * MAX_COLS + 32'(sw_j));
    op_addr    = AW'(32'(row_q) * MAX_COLS + 32'(col_q));
    sweep_last = (sw_j + IW'(2) >= eff_cols) && (sw_i + IW'(2) >= eff_rows);
    case (k_q)
      3'd0:    d_addr = op_addr;
      3'd1:    d_addr = op_addr + AW'(1);
      3'd2:    d_addr = op_addr - AW'(1);
      3'd3:    d_addr = op_addr + COL_OFS;
      default: d_addr = op_addr - COL_OFS;
    endcase
    d_delta   = (k_q == 3'd0) ? mag_q : (mag_q >>> 1);
    d_sum     = (HW+1)'(cur_rd0) + (HW+1)'(d_delta);
    cw_data   = sat24(32'(d_sum));
    nsum_next = (HW+2)'(up_q) + (HW+2)'(dn_q) + (HW+2)'(cur_rd0) + (HW+2)'(cur_rd1);
    // The lower neighbour of a read counts as zero below the last row.
    rd_dn     = (row_q + IW'(1) < eff_rows) ? cur_rd0 : '0;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (op)
            OP_TICK:    state_next = ST_TICK;
            OP_DISTURB: state_next = dist_ok ? ST_DRD : ST_FIN;
            OP_READ:    state_next = read_ok ? ST_RD0 : ST_FIN;
            default:    state_next = ST_FIN;
          endcase
        end
      end
      ST_TICK: state_next = step_now ? ST_SW0 : ST_FIN;
      ST_SW0:  state_next = ST_SW1;
      ST_SW1:  state_next = ST_SW2;
      ST_SW2:  state_next = ST_SWM;
      ST_SWM:  state_next = ST_SWS;
      ST_SWS:  state_next = ST_SWW;
      ST_SWW:  state_next = sweep_last ? ST_FIN : ST_SW0;
      ST_DRD:  state_next = ST_DWR;
      ST_DWR:  state_next = (k_q == 3'd4) ? ST_FIN : ST_DRD;
      ST_RD0:  state_next = ST_RD1;
      ST_RD1:  state_next = ST_RD2;
      ST_RD2:  state_next = ST_RD3;
      ST_RD3:  state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory requests per state.
  always_comb begin
    clr  = 1'b0;
    cwe  = 1'b0;
    pwe  = 1'b0;
    cra0 = sw_addr;
    cra1 = sw_addr;
    pra  = sw_addr;
    case (state)
      ST_CLEAR: clr = 1'b1;
      ST_SW0: begin
        cra0 = sw_addr - COL_OFS;
        cra1 = sw_addr + COL_OFS;
      end
      ST_SW1: begin
        cra0 = sw_addr - AW'(1);
        cra1 = sw_addr + AW'(1);
      end
      ST_SWW: pwe = 1'b1;
      ST_DRD: cra0 = d_addr;
      ST_DWR: cwe = 1'b1;
      ST_RD0: begin
        cra0 = op_addr;
        cra1 = op_addr + AW'(1);
      end
      ST_RD1: begin
        cra0 = op_addr - AW'(1);
        cra1 = op_addr - COL_OFS;
      end
      ST_RD2: cra0 = op_addr + COL_OFS;
      default: begin
        clr = 1'b0;
      end
    endcase
  end

  // Route current and previous roles onto the two memories.
  always_comb begin
    a_we     = clr || (current_is_b ? pwe : cwe);
    b_we     = clr || (current_is_b ? cwe : pwe);
    a_waddr  = clr ? clr_addr : (current_is_b ? sw_addr : d_addr);
    b_waddr  = clr ? clr_addr : (current_is_b ? d_addr : sw_addr);
    a_wdata  = clr ? '0 : (current_is_b ? pw_data : cw_data);
    b_wdata  = clr ? '0 : (current_is_b ? cw_data : pw_data);
    a_raddr0 = current_is_b ? pra : cra0;
    b_raddr0 = current_is_b ? cra0 : pra;
    cur_rd0  = current_is_b ? b_rd0 : a_rd0;
    cur_rd1  = current_is_b ? b_rd1 : a_rd1;
    prv_rd0  = current_is_b ? a_rd0 : b_rd0;
  end

  gsp_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid_a (
    .clk    (clk),
    .we     (a_we),
    .waddr  (a_waddr),
    .wdata  (a_wdata),
    .raddr0 (a_raddr0),
    .raddr1 (cra1),
    .rdata0 (a_rd0),
    .rdata1 (a_rd1)
  );

  gsp_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid_b (
    .clk    (clk),
    .we     (b_we),
    .waddr  (b_waddr),
    .wdata  (b_wdata),
    .raddr0 (b_raddr0),
    .raddr1 (cra1),
    .rdata0 (b_rd0),
    .rdata1 (b_rd1)
  );

  gsp_update u_update (
    .clk            (clk),
    .coef_prev      (coef_prev),
    .coef_center    (coef_center),
    .coef_neighbour (coef_neighbour),
    .prev_h         (prv_rd0),
    .cur_h          (cur_rd0),
    .nsum           (nsum_q),
    .res            (pw_data)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows      <= RST_GRID_ROWS;
      grid_cols      <= RST_GRID_COLS;
      time_step      <= RST_TIME_STEP;
      coef_prev      <= RST_COEF_PREV;
      coef_center    <= RST_COEF_CTR;
      coef_neighbour <= RST_COEF_NB;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GRID_ROWS: grid_rows      <= cfg_wdata[GW-1:0];
        REG_GRID_COLS: grid_cols      <= cfg_wdata[GW-1:0];
        REG_TIME_STEP: time_step      <= cfg_wdata[TW-1:0];
        REG_COEF_PREV: coef_prev      <= cfg_wdata[KW-1:0];
        REG_COEF_CTR:  coef_center    <= cfg_wdata[KW-1:0];
        REG_COEF_NB:   coef_neighbour <= cfg_wdata[KW-1:0];
        default:       grid_rows      <= grid_rows;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      current_is_b <= 1'b0;
      time_acc     <= '0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FIN);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == ST_TICK) begin
        time_acc <= step_now ? '0 : acc_sat;
      end
      if ((state == ST_SWW) && sweep_last) begin
        current_is_b <= !current_is_b;
      end
    end
  end

  // Working registers and result fields.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          row_q     <= in_row;
          col_q     <= in_col;
          mag_q     <= magnitude;
          elapsed_q <= elapsed_time;
          k_q       <= '0;
          height    <= '0;
          slope_x   <= '0;
          slope_z   <= '0;
          stepped   <= 1'b0;
          rejected  <= ((op == OP_DISTURB) && !dist_ok) || ((op == OP_READ) && !read_ok);
        end
      end
      ST_TICK: begin
        sw_i    <= IW'(1);
        sw_j    <= IW'(1);
        stepped <= step_now;
      end
      ST_SW1: begin
        up_q <= cur_rd0;
        dn_q <= cur_rd1;
      end
      ST_SW2: nsum_q <= nsum_next;
      ST_SWW: begin
        if (sw_j + IW'(2) >= eff_cols) begin
          sw_j <= IW'(1);
          sw_i <= sw_i + IW'(1);
        end else begin
          sw_j <= sw_j + IW'(1);
        end
      end
      ST_DWR: k_q <= k_q + 3'd1;
      ST_RD1: begin
        ht_q <= cur_rd0;
        rt_q <= (col_q + IW'(1) < eff_cols) ? cur_rd1 : '0;
      end
      ST_RD2: begin
        lf_q <= (col_q != '0) ? cur_rd0 : '0;
        up_q <= (row_q != '0) ? cur_rd1 : '0;
      end
      ST_RD3: begin
        dn_q    <= rd_dn;
        height  <= ht_q;
        slope_x <= SW'(rt_q) - SW'(lf_q);
        slope_z <= SW'(rd_dn) - SW'(up_q);
      end
      default: begin
        k_q <= k_q;
      end
    endcase
  end

  // The grids are only written by the clearing pass or by an item at work.
  `GSP_ASSERT(a_idle_no_write, clk, (!rst && state == ST_IDLE) |-> !(a_we || b_we), "grid written while idle")
  // Buffer roles swap only at the last cell of a sweep.
  `GSP_ASSERT_RST(a_swap_at_end, clk, rst, (current_is_b != $past(current_is_b)) |-> $past(state == ST_SWW), "grid roles swapped outside a sweep end")
  // An accepted item keeps the block busy in the following cycle.
  `GSP_ASSERT_RST(a_accept_busy, clk, rst, (start && !busy) |=> busy, "accepted item did not start")
  // A result never reports both a step and a rejection.
  `GSP_ASSERT_RST(a_flags_excl, clk, rst, done |-> !(stepped && rejected), "stepped and rejected both set")
  // During a sweep the current grid is never written.
  `GSP_ASSERT_RST(a_sweep_no_cur_write, clk, rst, (state == ST_SWW) |-> !cwe, "current grid written during a sweep")

endmodule
